FILE: src/pmct_pkg.sv
// Shared constants, types and the clamp function for the PS/2 cursor tracker.
// No dependencies; imported by ps2_mouse_cursor_tracker.
`default_nettype none

package pmct_pkg;

  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  // register addresses, decoded on paddr[2]
  localparam logic REG_SCREEN_COLUMNS = 1'b0;
  localparam logic REG_SCREEN_ROWS    = 1'b1;

  localparam logic [7:0] SCREEN_COLUMNS_RESET = 8'd80;
  localparam logic [7:0] SCREEN_ROWS_RESET    = 8'd25;
  localparam logic [7:0] CURSOR_COLUMN_RESET  = 8'd40;
  localparam logic [7:0] CURSOR_ROW_RESET     = 8'd12;

  // byte position within a packet
  localparam logic [1:0] POS_BUTTONS = 2'd0;
  localparam logic [1:0] POS_X_DELTA = 2'd1;
  localparam logic [1:0] POS_Y_DELTA = 2'd2;
  localparam logic [1:0] POS_UNUSED  = 2'd3;

  typedef logic [2:0] buttons_t;

  typedef struct packed {
    logic       from_aux;
    logic [7:0] data_byte;
  } in_item_t;

  // clamp a signed coordinate to 0 .. size-1, with a size of zero read as one
  function automatic logic [7:0] clamp_coord(input logic signed [9:0] v,
                                             input logic [7:0] size);
    logic [7:0] limit;
    limit = (size == 8'd0) ? 8'd0 : size - 8'd1;
    if (v < 10'sd0) begin
      clamp_coord = 8'd0;
    end else if (v > $signed({2'b00, limit})) begin
      clamp_coord = limit;
    end else begin
      clamp_coord = v[7:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/ps2_mouse_cursor_tracker.sv
// PS/2 mouse cursor tracker: packet assembly, cursor update and result register.
// Depends on pmct_pkg.
`default_nettype none

// Takes one controller byte per cycle on the in_ channel; bytes with in_from_aux
// low are dropped. Every third aux byte completes a mouse packet and produces
// one result on the out_ channel: the cursor position before and after the
// move (clamped to the screen size registers), the three button bits and the
// mask of buttons that changed since the previous packet. Throughput is one
// byte per cycle; the last byte of a packet waits in the input register until
// the result register is free, then moves into it together with the cursor
// update, and the result is offered from there. The cursor update is a
// single add-and-clamp stage between those two registers. Input is held off
// only while a finished result waits in the output register and the next byte
// would produce another one. Screen size registers sit at byte address 0
// (columns) and 4 (rows) and should only be written while the block is idle.
module ps2_mouse_cursor_tracker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_from_aux,
  input  wire  [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [7:0]                       out_old_column,
  output logic [7:0]                       out_old_row,
  output logic [7:0]                       out_new_column,
  output logic [7:0]                       out_new_row,
  output logic [2:0]                       out_button_bits,
  output logic [2:0]                       out_changed_buttons,
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [pmct_pkg::CfgAddrWidth-1:0] cfg_paddr,
  input  wire  [pmct_pkg::CfgDataWidth-1:0] cfg_pwdata,
  output logic [pmct_pkg::CfgDataWidth-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import pmct_pkg::*;

  logic [7:0] screen_columns_r;
  logic [7:0] screen_rows_r;

  logic       s1_valid_r;
  in_item_t   s1_item_r;

  logic [1:0] byte_pos_r;
  logic [7:0] button_byte_r;
  logic [7:0] x_delta_r;
  logic [7:0] cursor_column_r;
  logic [7:0] cursor_row_r;
  buttons_t   prev_buttons_r;

  logic       out_valid_r;
  logic [7:0] old_column_r;
  logic [7:0] old_row_r;
  logic [7:0] new_column_r;
  logic [7:0] new_row_r;
  buttons_t   button_bits_r;
  buttons_t   changed_r;

  logic              cfg_write;
  logic              s1_is_last;
  logic              s1_advance;
  logic              s1_take;
  logic              load_result;
  logic signed [9:0] column_sum;
  logic signed [9:0] row_sum;
  logic [7:0]        column_nxt;
  logic [7:0]        row_nxt;
  buttons_t          buttons_nxt;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    if (cfg_paddr[2] == REG_SCREEN_ROWS) begin
      cfg_prdata = {{(CfgDataWidth-8){1'b0}}, screen_rows_r};
    end else begin
      cfg_prdata = {{(CfgDataWidth-8){1'b0}}, screen_columns_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_columns_r <= SCREEN_COLUMNS_RESET;
      screen_rows_r    <= SCREEN_ROWS_RESET;
    end else if (cfg_write) begin
      if (cfg_paddr[2] == REG_SCREEN_COLUMNS) begin
        screen_columns_r <= cfg_pwdata[7:0];
      end else begin
        screen_rows_r <= cfg_pwdata[7:0];
      end
    end
  end

  // a byte in stage 1 completes a packet only at the third position
  assign s1_is_last  = s1_valid_r && s1_item_r.from_aux && (byte_pos_r == POS_Y_DELTA);
  assign s1_advance  = !s1_is_last || !out_valid_r || out_ready;
  assign s1_take     = s1_valid_r && s1_advance && s1_item_r.from_aux;
  assign load_result = s1_is_last && s1_advance;
  assign in_ready    = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r.from_aux  <= in_from_aux;
      s1_item_r.data_byte <= in_data_byte;
    end
  end

  // cursor update
  assign column_sum  = $signed({2'b00, cursor_column_r}) + $signed({{2{x_delta_r[7]}}, x_delta_r});
  assign row_sum     = $signed({2'b00, cursor_row_r})
                       - $signed({{2{s1_item_r.data_byte[7]}}, s1_item_r.data_byte});
  assign column_nxt  = clamp_coord(column_sum, screen_columns_r);
  assign row_nxt     = clamp_coord(row_sum, screen_rows_r);
  assign buttons_nxt = button_byte_r[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r      <= POS_BUTTONS;
      cursor_column_r <= CURSOR_COLUMN_RESET;
      cursor_row_r    <= CURSOR_ROW_RESET;
      prev_buttons_r  <= '0;
    end else if (s1_take) begin
      unique case (byte_pos_r)
        POS_X_DELTA: byte_pos_r <= POS_Y_DELTA;
        POS_Y_DELTA: begin
          byte_pos_r      <= POS_BUTTONS;
          cursor_column_r <= column_nxt;
          cursor_row_r    <= row_nxt;
          prev_buttons_r  <= buttons_nxt;
        end
        default:     byte_pos_r <= POS_X_DELTA;
      endcase
    end
  end

  // packet bytes hold no reset value; a packet never completes before both are stored
  always_ff @(posedge clk) begin
    if (s1_take) begin
      if (byte_pos_r == POS_X_DELTA) begin
        x_delta_r <= s1_item_r.data_byte;
      end else if (byte_pos_r != POS_Y_DELTA) begin
        button_byte_r <= s1_item_r.data_byte;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      old_column_r  <= cursor_column_r;
      old_row_r     <= cursor_row_r;
      new_column_r  <= column_nxt;
      new_row_r     <= row_nxt;
      button_bits_r <= buttons_nxt;
      changed_r     <= buttons_nxt ^ prev_buttons_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_old_column      = old_column_r;
  assign out_old_row         = old_row_r;
  assign out_new_column      = new_column_r;
  assign out_new_row         = new_row_r;
  assign out_button_bits     = button_bits_r;
  assign out_changed_buttons = changed_r;

  // the unused position code is never reached
  a_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r != POS_UNUSED)
    else $error("byte position reached unused code");

  // a loaded result carries the cursor the tracker now holds
  a_result_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    load_result |=> (out_new_column == cursor_column_r) && (out_new_row == cursor_row_r))
    else $error("result position differs from stored cursor");

  // the change mask is taken against the buttons of the packet before
  a_result_changed: assert property (@(posedge clk) disable iff (!rst_n)
    load_result |=> out_changed_buttons == (out_button_bits ^ $past(prev_buttons_r)))
    else $error("changed button mask inconsistent");

endmodule

`default_nettype wire

FILE: bench/ps2_mouse_cursor_tracker_tb.sv
// Testbench for ps2_mouse_cursor_tracker: drives controller bytes and screen sizes,
// predicts each cursor move in a scoreboard class and compares every result.
// Depends on pmct_pkg and the ps2_mouse_cursor_tracker RTL.

module ps2_mouse_cursor_tracker_tb;
  import pmct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] old_col;
    logic [7:0] old_row;
    logic [7:0] new_col;
    logic [7:0] new_row;
    buttons_t   buttons;
    buttons_t   changed;
  } cursor_move_t;

  class cursor_track_sb;
    logic [7:0]   columns;
    logic [7:0]   rows;
    logic [1:0]   position;
    logic [7:0]   button_byte;
    logic [7:0]   x_byte;
    logic [7:0]   col;
    logic [7:0]   row;
    buttons_t     last_buttons;
    cursor_move_t moves_due[$];
    int unsigned  errors;

    function new();
      columns      = SCREEN_COLUMNS_RESET;
      rows         = SCREEN_ROWS_RESET;
      position     = POS_BUTTONS;
      button_byte  = 8'd0;
      x_byte       = 8'd0;
      col          = CURSOR_COLUMN_RESET;
      row          = CURSOR_ROW_RESET;
      last_buttons = 3'd0;
      errors       = 0;
    endfunction

    function void set_size(logic idx, logic [7:0] value);
      if (idx == REG_SCREEN_COLUMNS) begin
        columns = value;
      end else begin
        rows = value;
      end
    endfunction

    // size zero behaves as size one
    function logic [7:0] fit(int v, logic [7:0] size);
      int edge_max;
      edge_max = (size == 8'd0) ? 0 : int'(size) - 1;
      if (v < 0) begin
        return 8'd0;
      end
      if (v > edge_max) begin
        return edge_max[7:0];
      end
      return v[7:0];
    endfunction

    function void note_byte(logic aux, logic [7:0] b);
      cursor_move_t m;
      if (!aux) begin
        return;
      end
      if (position == POS_X_DELTA) begin
        x_byte   = b;
        position = POS_Y_DELTA;
      end else if (position != POS_Y_DELTA) begin
        button_byte = b;
        position    = POS_X_DELTA;
      end else begin
        position  = POS_BUTTONS;
        m.old_col = col;
        m.old_row = row;
        col       = fit(int'(col) + int'($signed(x_byte)), columns);
        row       = fit(int'(row) - int'($signed(b)), rows);
        m.new_col = col;
        m.new_row = row;
        m.buttons = button_byte[2:0];
        m.changed = button_byte[2:0] ^ last_buttons;
        last_buttons = button_byte[2:0];
        moves_due.push_back(m);
      end
    endfunction

    function void check_move(cursor_move_t seen);
      cursor_move_t want;
      if (moves_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected result: old %0d,%0d new %0d,%0d buttons %b changed %b",
                   seen.old_col, seen.old_row, seen.new_col, seen.new_row,
                   seen.buttons, seen.changed);
        end
        return;
      end
      want = moves_due.pop_front();
      if (seen.old_col !== want.old_col || seen.old_row !== want.old_row ||
          seen.new_col !== want.new_col || seen.new_row !== want.new_row ||
          seen.buttons !== want.buttons || seen.changed !== want.changed) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch: expected old %0d,%0d new %0d,%0d buttons %b changed %b",
                   want.old_col, want.old_row, want.new_col, want.new_row,
                   want.buttons, want.changed);
          $display("          actual   old %0d,%0d new %0d,%0d buttons %b changed %b",
                   seen.old_col, seen.old_row, seen.new_col, seen.new_row,
                   seen.buttons, seen.changed);
        end
      end
    endfunction

    function int unsigned pending();
      return moves_due.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_from_aux;
  logic [7:0]              in_data_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic [7:0]              out_old_column;
  logic [7:0]              out_old_row;
  logic [7:0]              out_new_column;
  logic [7:0]              out_new_row;
  logic [2:0]              out_button_bits;
  logic [2:0]              out_changed_buttons;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CfgAddrWidth-1:0] cfg_paddr;
  logic [CfgDataWidth-1:0] cfg_pwdata;
  logic [CfgDataWidth-1:0] cfg_prdata;
  logic                    cfg_pready;

  cursor_track_sb sb = new();
  bit             calm;
  bit             hold_long;
  int unsigned    cycles = 0;

  ps2_mouse_cursor_tracker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_from_aux        (in_from_aux),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_old_column     (out_old_column),
    .out_old_row        (out_old_row),
    .out_new_column     (out_new_column),
    .out_new_row        (out_new_row),
    .out_button_bits    (out_button_bits),
    .out_changed_buttons(out_changed_buttons),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_move(cursor_move_t'({out_old_column, out_old_row, out_new_column,
                                    out_new_row, out_button_bits, out_changed_buttons}));
    end
  end

  // result side: short random stalls, plus one long hold-off on request
  initial begin : result_sink
    out_ready <= 1'b0;
    @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic aux, input logic [7:0] b);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_from_aux  <= aux;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(aux, b);
  endtask

  task automatic send_packet(input logic [7:0] buttons, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_byte(1'b1, buttons);
    send_byte(1'b1, dx);
    send_byte(1'b1, dy);
  endtask

  function automatic logic [7:0] pick_delta();
    logic [7:0] extremes[4];
    extremes = '{8'h7f, 8'h80, 8'h00, 8'hff};
    if ($urandom_range(0, 7) == 0) begin
      return extremes[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_packets(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_byte(1'b0, 8'($urandom_range(0, 255)));
      end
      // stray aux byte shifts packet framing
      if ($urandom_range(0, 24) == 0) begin
        send_byte(1'b1, 8'($urandom_range(0, 255)));
      end
      send_byte(1'b1, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
        send_byte(1'b0, 8'($urandom_range(0, 255)));
      end
      send_byte(1'b1, pick_delta());
      send_byte(1'b1, pick_delta());
    end
  endtask

  // wait for all results, then let any trailing byte clear the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_size(idx, value);
    @(posedge clk);
  endtask

  task automatic set_screen(input logic [7:0] columns, input logic [7:0] rows);
    write_reg(REG_SCREEN_COLUMNS, columns);
    write_reg(REG_SCREEN_ROWS, rows);
  endtask

  initial begin : stimulus
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_from_aux  <= 1'b0;
    in_data_byte <= 8'd0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    calm      = 1'b0;
    hold_long = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset screen size: clamp at both edges, dropped bytes inside a packet
    send_byte(1'b0, 8'hff);
    send_packet(8'h07, 8'h7f, 8'h80);
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'h55);
    send_byte(1'b1, 8'h80);
    send_byte(1'b1, 8'h7f);
    send_packet(8'hf8, 8'h00, 8'h00);
    send_packet(8'h05, 8'hff, 8'h01);
    send_packet(8'h02, 8'h01, 8'hff);
    settle();

    // widest screen, walk cursor to the far corner
    set_screen(8'd255, 8'd255);
    send_packet(8'h01, 8'h7f, 8'h80);
    send_packet(8'h01, 8'h7f, 8'h80);
    send_packet(8'h06, 8'h7f, 8'h80);
    settle();

    // shrink under the cursor: old position reported as stored, then clamped
    set_screen(8'd10, 8'd5);
    send_packet(8'h04, 8'h00, 8'h00);
    random_packets(20);
    settle();

    set_screen(8'd0, 8'd0);
    random_packets(12);
    settle();

    set_screen(8'd1, 8'd1);
    random_packets(12);
    settle();

    set_screen(8'd255, 8'd255);
    random_packets(25);

    for (int p = 0; p < 7; p++) begin
      settle();
      set_screen(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      if (p == 3) begin
        hold_long = 1'b1;
      end
      random_packets(18);
    end

    settle();
    calm = 1'b1;
    set_screen(SCREEN_COLUMNS_RESET, SCREEN_ROWS_RESET);
    random_packets(22);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: ps2_mouse_cursor_tracker.f
src/pmct_pkg.sv
src/ps2_mouse_cursor_tracker.sv
bench/ps2_mouse_cursor_tracker_tb.sv
